/* rtl/agbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package agbc_pkg;

  // Default build parameters
  localparam int AGBC_SAMPLE_COUNT = 256;
  localparam int AGBC_SAMPLE_WIDTH = 16;

  // Fixed field widths
  localparam int ONE_G_W = 15;
  localparam int BIAS_W  = 21;
  localparam int CMD_W   = 2;

  localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd4096;

  // Saturation limits of the bias registers
  localparam logic signed [BIAS_W-1:0] BIAS_MAX = 21'sh0FFFFF;
  localparam logic signed [BIAS_W-1:0] BIAS_MIN = 21'sh100000;

  // Command codes; the spare code behaves as init
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_RESTART  = 2'd1,
    CMD_INIT     = 2'd2,
    CMD_INIT_ALT = 2'd3
  } cmd_e;

  // Per-word control from the accumulator to the bias stage
  typedef struct packed {
    logic pass_done;   // this sample closed a pass
    logic restart;     // session restart (any command)
    logic clear_bias;  // init: bias back to zero
  } agbc_ctrl_t;

endpackage : agbc_pkg

`default_nettype wire

/* rtl/agbc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface agbc_in_if
  import agbc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = AGBC_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic [CMD_W-1:0]               cmd;
  logic signed [SAMPLE_WIDTH-1:0] acc_x;
  logic signed [SAMPLE_WIDTH-1:0] acc_y;
  logic signed [SAMPLE_WIDTH-1:0] acc_z;

  modport source (output valid, cmd, acc_x, acc_y, acc_z, input ready);
  modport sink   (input valid, cmd, acc_x, acc_y, acc_z, output ready);
endinterface : agbc_in_if

`default_nettype wire

/* rtl/agbc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface agbc_out_if
  import agbc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [BIAS_W-1:0] bias_x;
  logic signed [BIAS_W-1:0] bias_y;
  logic signed [BIAS_W-1:0] bias_z;
  logic                     status;
  logic                     pass_done;

  modport source (output valid, bias_x, bias_y, bias_z, status, pass_done, input ready);
  modport sink   (input valid, bias_x, bias_y, bias_z, status, pass_done, output ready);
endinterface : agbc_out_if

`default_nettype wire

/* rtl/agbc_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface agbc_cfg_if
  import agbc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ONE_G_W-1:0] one_g_lsb;

  modport source (output valid, one_g_lsb, input ready);
  modport sink   (input valid, one_g_lsb, output ready);
endinterface : agbc_cfg_if

`default_nettype wire

/* rtl/accel_gravity_bias_calibrator.sv */
// Accelerometer gravity-bias calibrator. Each sample word (cmd 0) adds the
// three axis samples into per-axis sums; the SAMPLE_COUNT-th sample of a
// pass (SAMPLE_COUNT must be a power of two) averages them by a flooring
// shift, removes one g (cfg one_g_lsb, reset 4096) toward zero from the
// axis of largest magnitude, subtracts the averages from the 21-bit
// saturating bias and sets status. cmd 1 restarts the pass and clears
// status; cmd 2 and 3 also zero the bias. Every input word yields one
// result word carrying the bias and status after that word. The block
// takes one word per clock while the output is not stalled; a word passes
// through the input register and its result is then registered in the output
// register, held there until taken while the next word is already accepted.
// Write one_g_lsb only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module accel_gravity_bias_calibrator
  import agbc_pkg::*;
#(
  parameter int SAMPLE_COUNT = AGBC_SAMPLE_COUNT,
  parameter int SAMPLE_WIDTH = AGBC_SAMPLE_WIDTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  agbc_in_if.sink     in_ch,
  agbc_out_if.source  out_ch,
  agbc_cfg_if.sink    cfg_ch
);

  logic                           s0_valid_r;
  cmd_e                           s0_cmd_r;
  logic signed [SAMPLE_WIDTH-1:0] s0_acc_r [3];
  logic                           out_valid_r;
  logic                           pass_done_r;
  logic [ONE_G_W-1:0]             one_g_r;
  logic                           adv;
  logic                           step;
  logic                           in_take;
  logic signed [SAMPLE_WIDTH-1:0] avg  [3];
  logic signed [BIAS_W-1:0]       bias [3];
  logic                           status;
  agbc_ctrl_t                     ctrl;

  // Handshake: the input register moves on when the output slot frees
  assign adv          = !out_valid_r || out_ch.ready;
  assign step         = s0_valid_r && adv;
  assign in_ch.ready  = !s0_valid_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_g_r <= ONE_G_RESET;
    end else if (cfg_ch.valid) begin
      one_g_r <= cfg_ch.one_g_lsb;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s0_valid_r <= in_ch.valid;
      if (adv)         out_valid_r <= s0_valid_r;
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_cmd_r    <= cmd_e'(in_ch.cmd);
      s0_acc_r[0] <= in_ch.acc_x;
      s0_acc_r[1] <= in_ch.acc_y;
      s0_acc_r[2] <= in_ch.acc_z;
    end
  end

  agbc_accum #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (step),
    .cmd   (s0_cmd_r),
    .acc   (s0_acc_r),
    .avg   (avg),
    .ctrl  (ctrl)
  );

  agbc_bias #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_bias (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (step),
    .ctrl   (ctrl),
    .avg    (avg),
    .one_g  (one_g_r),
    .bias   (bias),
    .status (status)
  );

  // Pass-done flag of the word in the output register
  always_ff @(posedge clk) begin
    if (step) pass_done_r <= ctrl.pass_done;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bias_x    = bias[0];
  assign out_ch.bias_y    = bias[1];
  assign out_ch.bias_z    = bias[2];
  assign out_ch.status    = status;
  assign out_ch.pass_done = pass_done_r;

endmodule : accel_gravity_bias_calibrator

`default_nettype wire

/* rtl/agbc_accum.sv */
`timescale 1ns / 1ps
`default_nettype none

// Per-axis sample accumulator and pass counter. Produces the floored
// averages of the pass that the current sample closes.
module agbc_accum
  import agbc_pkg::*;
#(
  parameter int SAMPLE_COUNT = AGBC_SAMPLE_COUNT,
  parameter int SAMPLE_WIDTH = AGBC_SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire cmd_e                           cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0] acc [3],
  output logic signed [SAMPLE_WIDTH-1:0]      avg [3],
  output agbc_ctrl_t                          ctrl
);

  // SAMPLE_COUNT is a power of two: the average is an arithmetic shift
  localparam int LOG2  = $clog2(SAMPLE_COUNT);
  localparam int CNT_W = LOG2;
  localparam int SUM_W = SAMPLE_WIDTH + LOG2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);

  logic signed [SUM_W-1:0] sum_r   [3];
  logic signed [SUM_W-1:0] sum_nxt [3];
  logic [CNT_W-1:0]        cnt_r;
  logic                    is_sample;

  assign is_sample = (cmd == CMD_SAMPLE);

  // Running sums including this sample, and their floored averages
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = sum_r[i] + SUM_W'(acc[i]);
      avg[i]     = SAMPLE_WIDTH'(sum_nxt[i] >>> LOG2);
    end
  end

  // Control decode for the bias stage
  always_comb begin
    ctrl.pass_done  = is_sample && (cnt_r == CNT_LAST);
    ctrl.restart    = !is_sample;
    unique case (cmd) inside
      CMD_INIT, CMD_INIT_ALT: ctrl.clear_bias = 1'b1;
      default:                ctrl.clear_bias = 1'b0;
    endcase
  end

  // Sums and count: cleared by any command or at the end of a pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else if (en) begin
      if (ctrl.restart || ctrl.pass_done) begin
        cnt_r <= '0;
        for (int i = 0; i < 3; i++) sum_r[i] <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
        for (int i = 0; i < 3; i++) sum_r[i] <= sum_nxt[i];
      end
    end
  end

endmodule : agbc_accum

`default_nettype wire

/* rtl/agbc_bias.sv */
`timescale 1ns / 1ps
`default_nettype none

// End-of-pass finalize: pick the gravity axis, strip one g from it, and
// fold the averages into the saturating bias. Commands clear status.
module agbc_bias
  import agbc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = AGBC_SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire agbc_ctrl_t                     ctrl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] avg [3],
  input  wire logic [ONE_G_W-1:0]             one_g,
  output logic signed [BIAS_W-1:0]            bias [3],
  output logic                                status
);

  localparam int ADJ_W  = ((SAMPLE_WIDTH > ONE_G_W + 1) ? SAMPLE_WIDTH : ONE_G_W + 1) + 1;
  localparam int DIFF_W = ((ADJ_W > BIAS_W) ? ADJ_W : BIAS_W) + 1;

  logic [SAMPLE_WIDTH-1:0]   mag [3];
  logic [2:0]                sel;
  logic signed [ADJ_W-1:0]   g_ext;
  logic signed [ADJ_W-1:0]   adj  [3];
  logic signed [DIFF_W-1:0]  diff [3];
  logic signed [BIAS_W-1:0]  sat  [3];
  logic signed [BIAS_W-1:0]  bias_r [3];
  logic                      status_r;

  // Magnitudes; the most negative value reads as its unsigned magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = avg[i][SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-avg[i]) : SAMPLE_WIDTH'(avg[i]);
    end
  end

  // Largest magnitude, strict compares so ties go to the later axis
  always_comb begin
    sel = 3'b100;
    if (mag[0] > mag[1] && mag[0] > mag[2]) sel = 3'b001;
    else if (mag[1] > mag[2])               sel = 3'b010;
  end

  // Remove one g toward zero on the chosen axis, then subtract and clamp
  assign g_ext = ADJ_W'($signed({1'b0, one_g}));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      adj[i] = ADJ_W'(avg[i]);
      if (sel[i]) begin
        adj[i] = avg[i][SAMPLE_WIDTH-1] ? (ADJ_W'(avg[i]) + g_ext)
                                        : (ADJ_W'(avg[i]) - g_ext);
      end
      diff[i] = DIFF_W'(bias_r[i]) - DIFF_W'(adj[i]);
      if (diff[i] > DIFF_W'(BIAS_MAX))      sat[i] = BIAS_MAX;
      else if (diff[i] < DIFF_W'(BIAS_MIN)) sat[i] = BIAS_MIN;
      else                                  sat[i] = BIAS_W'(diff[i]);
    end
  end

  // Bias and status state; their values are the result word's fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 1'b0;
      for (int i = 0; i < 3; i++) bias_r[i] <= '0;
    end else if (en) begin
      if (ctrl.restart) begin
        status_r <= 1'b0;
        if (ctrl.clear_bias) begin
          for (int i = 0; i < 3; i++) bias_r[i] <= '0;
        end
      end else if (ctrl.pass_done) begin
        status_r <= 1'b1;
        for (int i = 0; i < 3; i++) bias_r[i] <= sat[i];
      end
    end
  end

  assign bias   = bias_r;
  assign status = status_r;

endmodule : agbc_bias

`default_nettype wire

/* rtl/agbc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module agbc_checker
  import agbc_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [BIAS_W-1:0] bias_x,
  input wire logic                     status,
  input wire logic                     pass_done
);

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A finished pass always reports calibrated status
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pass_done |-> status)
    else $error("pass_done without status");

  // Two passes cannot close on consecutive words
  a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && pass_done |=> !(out_valid && pass_done))
    else $error("pass_done on back-to-back words");

  // Input back-pressure only while a result is stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // A stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bias_x) && $stable(status))
    else $error("stalled result changed");

endmodule : agbc_checker

bind accel_gravity_bias_calibrator agbc_checker u_agbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .bias_x    (out_ch.bias_x),
  .status    (out_ch.status),
  .pass_done (out_ch.pass_done)
);

`default_nettype wire

/* sim/agbc_bias_monitor.sv */
`timescale 1ns / 1ps

// Watches the sample, result and one_g channels of the calibrator, predicts
// each result word and compares it with what comes out.
module agbc_bias_monitor
  import agbc_pkg::*;
#(
  parameter int SAMPLE_COUNT = AGBC_SAMPLE_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  agbc_in_if   in_mon,
  agbc_out_if  out_mon,
  agbc_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   words_seen,
  output int   passes_seen,
  output int   sat_words
);

  localparam int AVG_SHIFT = $clog2(SAMPLE_COUNT);
  localparam int SW        = AGBC_SAMPLE_WIDTH;

  typedef struct packed {
    logic signed [BIAS_W-1:0] bx;
    logic signed [BIAS_W-1:0] by;
    logic signed [BIAS_W-1:0] bz;
    logic                     status;
    logic                     pass_done;
  } bias_word_t;

  // Predicted calibrator state
  int   sum_q[3];
  int   count_q;
  int   bias_q[3];
  logic status_q;
  int   one_g_q;

  bias_word_t bias_words_due[$];
  int errors = 0;
  int words  = 0;
  int passes = 0;
  int sats   = 0;

  // Apply one input word to the predicted state, return the result word
  function automatic bias_word_t calibrate_word(cmd_e cmd, logic signed [SW-1:0] sx,
                                                logic signed [SW-1:0] sy,
                                                logic signed [SW-1:0] sz);
    bias_word_t w;
    int         avg[3];
    int         mag[3];
    int         pick;
    int         v;
    logic       closed;
    closed = 1'b0;
    if (cmd != CMD_SAMPLE) begin
      count_q  = 0;
      status_q = 1'b0;
      sum_q    = '{0, 0, 0};
      // init and the spare code also drop the bias
      if (cmd != CMD_RESTART) bias_q = '{0, 0, 0};
    end else begin
      sum_q[0] += int'(sx);
      sum_q[1] += int'(sy);
      sum_q[2] += int'(sz);
      count_q++;
      if (count_q >= SAMPLE_COUNT) begin
        // flooring average, then pick the dominant axis (ties go later)
        for (int i = 0; i < 3; i++) begin
          avg[i] = sum_q[i] >>> AVG_SHIFT;
          mag[i] = (avg[i] < 0) ? -avg[i] : avg[i];
        end
        if (mag[0] > mag[1] && mag[0] > mag[2]) pick = 0;
        else if (mag[1] > mag[2])                pick = 1;
        else                                     pick = 2;
        // take one g off toward zero; zero counts as non-negative
        if (avg[pick] < 0) avg[pick] += one_g_q;
        else               avg[pick] -= one_g_q;
        for (int i = 0; i < 3; i++) begin
          v = bias_q[i] - avg[i];
          if (v > int'(BIAS_MAX))      v = int'(BIAS_MAX);
          else if (v < int'(BIAS_MIN)) v = int'(BIAS_MIN);
          bias_q[i] = v;
          sum_q[i]  = 0;
        end
        count_q  = 0;
        status_q = 1'b1;
        closed   = 1'b1;
      end
    end
    w.bx        = BIAS_W'(bias_q[0]);
    w.by        = BIAS_W'(bias_q[1]);
    w.bz        = BIAS_W'(bias_q[2]);
    w.status    = status_q;
    w.pass_done = closed;
    return w;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bias_word_t want;
    if (!rst_n) begin
      sum_q    = '{0, 0, 0};
      count_q  = 0;
      bias_q   = '{0, 0, 0};
      status_q = 1'b0;
      one_g_q  = int'(ONE_G_RESET);
      bias_words_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) one_g_q = int'(cfg_mon.one_g_lsb);
      if (in_mon.valid && in_mon.ready) begin
        bias_words_due.push_back(calibrate_word(cmd_e'(in_mon.cmd), in_mon.acc_x,
                                                in_mon.acc_y, in_mon.acc_z));
      end
      if (out_mon.valid && out_mon.ready) begin
        words++;
        if (bias_words_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual bias %0d %0d %0d",
                   $time, $signed(out_mon.bias_x), $signed(out_mon.bias_y),
                   $signed(out_mon.bias_z));
        end else begin
          want = bias_words_due.pop_front();
          check_field("bias_x", $signed(want.bx), $signed(out_mon.bias_x));
          check_field("bias_y", $signed(want.by), $signed(out_mon.bias_y));
          check_field("bias_z", $signed(want.bz), $signed(out_mon.bias_z));
          check_field("status", want.status, out_mon.status);
          check_field("pass_done", want.pass_done, out_mon.pass_done);
          if (want.pass_done) passes++;
          if (want.bx == BIAS_MAX || want.bx == BIAS_MIN || want.by == BIAS_MAX ||
              want.by == BIAS_MIN || want.bz == BIAS_MAX || want.bz == BIAS_MIN) begin
            sats++;
          end
        end
      end
    end
    fail_count  <= errors;
    pending     <= bias_words_due.size();
    words_seen  <= words;
    passes_seen <= passes;
    sat_words   <= sats;
  end

endmodule

/* sim/accel_gravity_bias_calibrator_tb.sv */
`timescale 1ns / 1ps

module accel_gravity_bias_calibrator_tb;
  import agbc_pkg::*;

  localparam int PASS_LEN     = AGBC_SAMPLE_COUNT;
  localparam int RAMP_PASSES  = 2;
  localparam int RANDOM_WORDS = 250;
  localparam int CYCLE_LIMIT  = 1_500_000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_e;

  logic clk;
  logic rst_n;

  agbc_in_if  in_bus ();
  agbc_out_if out_bus ();
  agbc_cfg_if cfg_bus ();

  int fail_count;
  int pending;
  int words_seen;
  int passes_seen;
  int sat_words;
  int burst_left = 0;
  bit steady     = 1'b0;
  int one_g_now  = int'(ONE_G_RESET);
  int cycles     = 0;

  accel_gravity_bias_calibrator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  agbc_bias_monitor i_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_mon     (cfg_bus),
    .fail_count  (fail_count),
    .pending     (pending),
    .words_seen  (words_seen),
    .passes_seen (passes_seen),
    .sat_words   (sat_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles == CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Result side: ready follows a changing stall pattern
  initial begin
    rx_mode_e mode;
    int       span;
    int       tick;
    tick          = 0;
    out_bus.ready = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          RX_OPEN:     out_bus.ready = 1'b1;
          RX_RANDOM:   out_bus.ready = ($urandom_range(0, 2) != 0);
          RX_PERIODIC: out_bus.ready = (tick % 5 != 0);
          default:     out_bus.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Send one word; words go out in bursts with random gaps in between
  task automatic send_word(cmd_e cmd, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady && $urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_bus.valid = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end
    end
    @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.cmd   = cmd;
    in_bus.acc_x = x;
    in_bus.acc_y = y;
    in_bus.acc_z = z;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
  endtask

  // Hold off until every result word is back, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    burst_left   = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_one_g(int value);
    settle();
    @(negedge clk);
    cfg_bus.valid     = 1'b1;
    cfg_bus.one_g_lsb = ONE_G_W'(value);
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    one_g_now     = value;
  endtask

  // Samples of a device resting on one face: gravity on one axis, offsets, noise
  task automatic run_tilt(int count);
    int                 axis;
    int                 sgn;
    int                 spread;
    int                 off[3];
    int                 v;
    logic signed [15:0] s[3];
    axis   = $urandom_range(0, 2);
    sgn    = ($urandom_range(0, 1) != 0) ? 1 : -1;
    spread = $urandom_range(0, 300);
    foreach (off[i]) off[i] = int'($urandom_range(0, 4000)) - 2000;
    repeat (count) begin
      for (int i = 0; i < 3; i++) begin
        v = off[i] + int'($urandom_range(0, 2 * spread)) - spread;
        if (i == axis) v += sgn * one_g_now;
        if (v > 32767)       s[i] = 16'sh7FFF;
        else if (v < -32768) s[i] = 16'sh8000;
        else                 s[i] = 16'(v);
      end
      send_word(CMD_SAMPLE, s[0], s[1], s[2]);
    end
  endtask

  // Mostly full orientation passes, some noise passes and broken passes
  task automatic run_random(int target);
    int sent;
    int kind;
    int n;
    sent = 0;
    while (sent < target) begin
      kind   = $urandom_range(0, 99);
      steady = ($urandom_range(0, 4) == 0);
      if (kind < 65) begin
        run_tilt(PASS_LEN);
        sent += PASS_LEN;
      end else if (kind < 80) begin
        repeat (PASS_LEN) send_word(CMD_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
        sent += PASS_LEN;
      end else if (kind < 93) begin
        n = $urandom_range(1, PASS_LEN - 1);
        run_tilt(n);
        send_word(cmd_e'($urandom_range(1, 3)), 16'($urandom), 16'($urandom), 16'($urandom));
        sent += n + 1;
      end else begin
        send_word(cmd_e'($urandom_range(1, 3)), 16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.cmd        = CMD_SAMPLE;
    in_bus.acc_x      = '0;
    in_bus.acc_y      = '0;
    in_bus.acc_z      = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.one_g_lsb = ONE_G_RESET;
    rst_n             = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes and every command, samples ignored on commands
    send_word(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh0000);
    send_word(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 16'shFFFF);
    send_word(CMD_RESTART, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(CMD_SAMPLE, 16'sh0001, 16'shFFFF, 16'sh8000);
    send_word(CMD_INIT, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(CMD_SAMPLE, 16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_word(CMD_INIT_ALT, 16'sh5555, 16'shAAAA, 16'sh0F0F);
    send_word(CMD_SAMPLE, 16'shAAAA, 16'sh5555, 16'shF0F0);
    send_word(CMD_INIT, 16'sh0000, 16'sh0000, 16'sh0000);

    // All-zero pass: three-way tie lands on z, zero average loses one g
    repeat (PASS_LEN) send_word(CMD_SAMPLE, 16'sh0000, 16'sh0000, 16'sh0000);
    // x and y tie in magnitude, y wins
    repeat (PASS_LEN) send_word(CMD_SAMPLE, 16'sd1000, -16'sd1000, 16'sd7);

    // Smallest one g; full-scale passes on all three axes, x/z tie picks z
    write_one_g(1);
    send_word(CMD_INIT, 16'sh0000, 16'sh0000, 16'sh0000);
    for (int p = 0; p < RAMP_PASSES; p++) begin
      steady = (p < RAMP_PASSES / 2);
      repeat (PASS_LEN) send_word(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh8000);
    end
    steady = 1'b0;
    send_word(CMD_RESTART, 16'sh1234, 16'sh4321, 16'sh0F0F);
    send_word(CMD_INIT, 16'sh0000, 16'sh0000, 16'sh0000);

    // Random phases over several one g settings
    write_one_g(32767);
    run_random(RANDOM_WORDS);
    write_one_g($urandom_range(2, 32766));
    run_random(RANDOM_WORDS);
    write_one_g(int'(ONE_G_RESET));
    run_random(RANDOM_WORDS);

    settle();
    $display("Checked %0d result words, %0d finished passes, %0d with a saturated bias.",
             words_seen, passes_seen, sat_words);
    $display("one_g at 4096, 1, 32767 and a random value; restart, init and spare code mixed in.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/agbc_pkg.sv
rtl/agbc_in_if.sv
rtl/agbc_out_if.sv
rtl/agbc_cfg_if.sv
rtl/agbc_accum.sv
rtl/agbc_bias.sv
rtl/accel_gravity_bias_calibrator.sv
rtl/agbc_checker.sv
sim/agbc_bias_monitor.sv
sim/accel_gravity_bias_calibrator_tb.sv
